// ----- rtl/rpn_stack_calculator_assert.svh -----
// ----------------------------------------------------------------------------
// rpn stack calculator assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

`ifndef SYNTH
`define RSC_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsc assertion failed: same-cycle implication");
`define RSC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsc assertion failed: next-cycle implication");
`else
`define RSC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define RSC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsc_pkg
// shared types and constants of the rpn stack calculator
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int STACK_DEPTH = 64;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_DROP = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_REPLY
  } state_t;

  // what a stack cell loads this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT
  } cell_mode_t;

endpackage

// ----- rtl/rpn_stack_calculator.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// reverse polish integer calculator on a row of shifting stack cells
// ----------------------------------------------------------------------------
// usage:
//   a token transfers in at a clock edge with start high and busy low: op
//   selects push, add, subtract, multiply, divide or drop, push_value is
//   the value pushed. every token gives one result, shown for exactly one
//   cycle with done high: top_value (zero on an empty stack), depth and
//   status. the receiver cannot hold a result off.
//   a token passes through the decode state and then the reply state, where
//   its result is shown and busy is low again, so the next token can
//   transfer while a result is shown. divide waits in the divide state for
//   the iterative divider, which finds one quotient bit per cycle.
//   the stack is a chain of cells, cell 0 being the top; push shifts the
//   chain down, drop and the arithmetic ops shift it up.
//   reset clears the depth and the control state; cell contents are left
//   as they are and are never shown while the stack is empty.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_assert.svh"

module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           op,
  input  logic signed [31:0]                   push_value,
  output logic                                 done,
  output logic signed [31:0]                   top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     depth,
  output logic [1:0]                           status
);

  localparam int W  = rsc_pkg::DATA_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  rsc_pkg::state_t     state;
  rsc_pkg::state_t     state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  rsc_pkg::status_t    result_status;
  rsc_pkg::status_t    result_status_next;
  rsc_pkg::op_t        cur_op;
  logic [W-1:0]        cur_value;

  rsc_pkg::cell_mode_t mode_top;
  rsc_pkg::cell_mode_t mode_rest;
  logic [W-1:0]        top_in;
  logic [W-1:0]        alu_result;
  logic                div_start;
  logic                div_done;
  logic [W-1:0]        div_quotient;
  logic                accept;

  logic [W-1:0]        cell_data [STACK_DEPTH];

  assign accept = start && !busy;

  // chain of stack cells, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rsc_cell u_cell (
      .clk       (clk),
      .mode      ((i == 0) ? mode_top : mode_rest),
      .prev_data ((i == 0) ? top_in : cell_data[(i == 0) ? 0 : i - 1]),
      .next_data (cell_data[(i == STACK_DEPTH - 1) ? i : i + 1]),
      .data      (cell_data[i])
    );
  end

  rsc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cell_data[1]),
    .divisor  (cell_data[0]),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // left operand is the entry below the top
  always_comb begin
    case (cur_op)
      rsc_pkg::OP_ADD: alu_result = cell_data[1] + cell_data[0];
      rsc_pkg::OP_SUB: alu_result = cell_data[1] - cell_data[0];
      rsc_pkg::OP_MUL: alu_result = cell_data[1] * cell_data[0];
      default:         alu_result = cell_data[1] + cell_data[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rsc_pkg::S_IDLE;
      count         <= '0;
      result_status <= rsc_pkg::ST_OK;
    end else begin
      state         <= state_next;
      count         <= count_next;
      result_status <= result_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op    <= rsc_pkg::op_t'(op);
      cur_value <= W'(push_value);
    end
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    result_status_next = result_status;
    mode_top           = rsc_pkg::CELL_HOLD;
    mode_rest          = rsc_pkg::CELL_HOLD;
    top_in             = alu_result;
    div_start          = 1'b0;
    unique case (state)
      rsc_pkg::S_IDLE,
      rsc_pkg::S_REPLY: begin
        state_next = accept ? rsc_pkg::S_DECODE : rsc_pkg::S_IDLE;
      end
      rsc_pkg::S_DECODE: begin
        state_next         = rsc_pkg::S_REPLY;
        result_status_next = rsc_pkg::ST_OK;
        case (cur_op)
          rsc_pkg::OP_PUSH: begin
            if (count == CW'(STACK_DEPTH)) begin
              result_status_next = rsc_pkg::ST_OVERFLOW;
            end else begin
              top_in     = cur_value;
              mode_top   = rsc_pkg::CELL_TAKE_PREV;
              mode_rest  = rsc_pkg::CELL_TAKE_PREV;
              count_next = count + CW'(1);
            end
          end
          rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL: begin
            if (count < CW'(2)) begin
              result_status_next = rsc_pkg::ST_UNDERFLOW;
            end else begin
              mode_top   = rsc_pkg::CELL_TAKE_PREV;
              mode_rest  = rsc_pkg::CELL_TAKE_NEXT;
              count_next = count - CW'(1);
            end
          end
          rsc_pkg::OP_DIV: begin
            if (count < CW'(2)) begin
              result_status_next = rsc_pkg::ST_UNDERFLOW;
            end else if (cell_data[0] == '0) begin
              result_status_next = rsc_pkg::ST_DIV_ZERO;
            end else begin
              div_start  = 1'b1;
              state_next = rsc_pkg::S_DIV;
            end
          end
          rsc_pkg::OP_DROP: begin
            if (count == '0) begin
              result_status_next = rsc_pkg::ST_UNDERFLOW;
            end else begin
              mode_top   = rsc_pkg::CELL_TAKE_NEXT;
              mode_rest  = rsc_pkg::CELL_TAKE_NEXT;
              count_next = count - CW'(1);
            end
          end
          default: begin
            // undefined codes do nothing
          end
        endcase
      end
      rsc_pkg::S_DIV: begin
        top_in = div_quotient;
        if (div_done) begin
          mode_top   = rsc_pkg::CELL_TAKE_PREV;
          mode_rest  = rsc_pkg::CELL_TAKE_NEXT;
          count_next = count - CW'(1);
          state_next = rsc_pkg::S_REPLY;
        end
      end
      default: begin
        state_next = rsc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state == rsc_pkg::S_DECODE) || (state == rsc_pkg::S_DIV);
  assign done      = (state == rsc_pkg::S_REPLY);
  assign top_value = (count != '0) ? cell_data[0] : '0;
  assign depth     = count;
  assign status    = result_status;

  `RSC_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `RSC_ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done)
  `RSC_ASSERT_IMPL(a_depth_bound, clk, rst, done, depth <= CW'(STACK_DEPTH))
  `RSC_ASSERT_IMPL(a_overflow_full, clk, rst, done && status == rsc_pkg::ST_OVERFLOW, depth == CW'(STACK_DEPTH))
  `RSC_ASSERT_IMPL(a_div_done_waited, clk, rst, div_done, state == rsc_pkg::S_DIV)

endmodule

// ----- rtl/rsc_cell.sv -----
// ----------------------------------------------------------------------------
// rsc_cell
// one stack entry; loads from the neighbor above or below, or holds
// ----------------------------------------------------------------------------
module rsc_cell (
  input  logic                             clk,
  input  rsc_pkg::cell_mode_t              mode,
  input  logic [rsc_pkg::DATA_WIDTH-1:0]   prev_data,
  input  logic [rsc_pkg::DATA_WIDTH-1:0]   next_data,
  output logic [rsc_pkg::DATA_WIDTH-1:0]   data
);

  always_ff @(posedge clk) begin
    case (mode)
      rsc_pkg::CELL_TAKE_PREV: data <= prev_data;
      rsc_pkg::CELL_TAKE_NEXT: data <= next_data;
      default:                 data <= data;
    endcase
  end

endmodule

// ----- rtl/rsc_divider.sv -----
// ----------------------------------------------------------------------------
// rsc_divider
// radix-2 restoring signed divider, truncates toward zero, one bit a cycle
// ----------------------------------------------------------------------------
module rsc_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rsc_pkg::DATA_WIDTH-1:0]   dividend,
  input  logic [rsc_pkg::DATA_WIDTH-1:0]   divisor,
  output logic [rsc_pkg::DATA_WIDTH-1:0]   quotient,
  output logic                             done
);

  localparam int W  = rsc_pkg::DATA_WIDTH;
  localparam int CW = $clog2(W);

  logic          running;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  mag_div;
  logic          negate;

  logic [W-1:0]  dividend_mag;
  logic [W-1:0]  divisor_mag;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign dividend_mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;
  assign divisor_mag  = divisor[W-1]  ? (~divisor  + W'(1)) : divisor;
  assign shifted      = {rem, quo[W-1]};
  assign diff         = shifted - {1'b0, mag_div};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (start) begin
        running <= 1'b1;
        done    <= 1'b0;
      end else if (running && cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt     <= CW'(W - 1);
      rem     <= '0;
      quo     <= dividend_mag;
      mag_div <= divisor_mag;
      negate  <= dividend[W-1] ^ divisor[W-1];
    end else if (running) begin
      cnt <= cnt - CW'(1);
      // keep the difference only when it did not go negative
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = negate ? (~quo + W'(1)) : quo;

endmodule

// ----- tb/tb_rpn_stack_calculator.sv -----
// ----------------------------------------------------------------------------
// tb_rpn_stack_calculator
// drives rpn tokens through the calculator and checks every result against a
// local stack model: directed corner cases first (underflow, wrap, divide,
// unknown ops), then random token streams under three idle mixes, each with
// a full-stack test and a drain partway through
module tb_rpn_stack_calculator;
  import rsc_pkg::*;

  localparam int          DEPTH_W   = $clog2(STACK_DEPTH + 1);
  localparam logic [2:0]  OP_NOP6   = 3'd6;
  localparam logic [2:0]  OP_NOP7   = 3'd7;
  localparam logic [31:0] VAL_MAX   = 32'h7fff_ffff;
  localparam logic [31:0] VAL_MIN   = 32'h8000_0000;
  localparam logic [31:0] VAL_MONE  = 32'hffff_ffff;
  localparam int          MAX_PRINT = 40;

  typedef struct {
    logic [31:0]        top;
    logic [DEPTH_W-1:0] depth;
    status_t            status;
  } calc_result_t;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      start      = 1'b0;
  logic [2:0]                op         = 3'd0;
  logic signed [31:0]        push_value = '0;
  logic                      busy;
  logic                      done;
  logic signed [31:0]        top_value;
  logic [DEPTH_W-1:0]        depth;
  logic [1:0]                status;

  // local copy of the stack, index calc_depth-1 is the top
  logic [31:0]  calc_stack [STACK_DEPTH];
  int           calc_depth = 0;
  calc_result_t calc_results_q [$];
  int           idle_pct   = 0;
  int           errors     = 0;

  rpn_stack_calculator #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .push_value (push_value),
    .done       (done),
    .top_value  (top_value),
    .depth      (depth),
    .status     (status)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  // apply one token to the local stack and queue the result it must give
  task automatic calc_token(input logic [2:0] code, input logic [31:0] val);
    calc_result_t res;
    logic [31:0]  a;
    logic [31:0]  b;
    longint       la;
    longint       lb;
    res.status = ST_OK;
    case (code)
      OP_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          calc_stack[calc_depth] = val;
          calc_depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (calc_depth < 2) begin
          res.status = ST_UNDERFLOW;
        end else begin
          b = calc_stack[calc_depth-1];
          a = calc_stack[calc_depth-2];
          if (code == OP_DIV && b == '0) begin
            res.status = ST_DIV_ZERO;
          end else begin
            case (code)
              OP_ADD:  calc_stack[calc_depth-2] = a + b;
              OP_SUB:  calc_stack[calc_depth-2] = a - b;
              OP_MUL:  calc_stack[calc_depth-2] = a * b;
              default: begin
                // 64-bit quotient so that min / -1 wraps instead of trapping
                la = $signed(a);
                lb = $signed(b);
                calc_stack[calc_depth-2] = 32'(la / lb);
              end
            endcase
            calc_depth--;
          end
        end
      end
      OP_DROP: begin
        if (calc_depth == 0) res.status = ST_UNDERFLOW;
        else calc_depth--;
      end
      default: ;
    endcase
    res.top   = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
    res.depth = DEPTH_W'(calc_depth);
    calc_results_q.push_back(res);
  endtask

  // one token transfer; start stays high unless an idle gap follows
  task automatic send_token(input logic [2:0] code, input logic [31:0] val);
    start      <= 1'b1;
    op         <= code;
    push_value <= val;
    do @(negedge clk); while (busy);
    @(posedge clk);
    calc_token(code, val);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (calc_results_q.size() != 0);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return VAL_MAX;
      2:       return VAL_MIN;
      3:       return VAL_MONE;
      4, 5:    return 32'($signed($urandom_range(40)) - 20);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_underflow();
    send_token(OP_DROP, $urandom());
    send_token(OP_ADD, $urandom());
    send_token(OP_PUSH, VAL_MAX);
    send_token(OP_SUB, $urandom());
    send_token(OP_DROP, $urandom());
  endtask

  task automatic test_wrap_arith();
    send_token(OP_PUSH, VAL_MAX);
    send_token(OP_PUSH, 32'd1);
    send_token(OP_ADD, '0);
    send_token(OP_PUSH, 32'd1);
    send_token(OP_SUB, '0);
    send_token(OP_PUSH, VAL_MIN);
    send_token(OP_MUL, '0);
  endtask

  task automatic test_divide_cases();
    // min / -1 wraps back to min
    send_token(OP_PUSH, VAL_MONE);
    send_token(OP_DIV, '0);
    // zero divisor leaves the stack alone
    send_token(OP_PUSH, '0);
    send_token(OP_DIV, '0);
    send_token(OP_DROP, '0);
    send_token(OP_DROP, '0);
    // zero dividend is fine
    send_token(OP_PUSH, '0);
    send_token(OP_PUSH, 32'hffff_fff9);
    send_token(OP_DIV, '0);
    send_token(OP_DROP, '0);
    // truncation toward zero
    send_token(OP_PUSH, 32'hffff_fff9);
    send_token(OP_PUSH, 32'd2);
    send_token(OP_DIV, '0);
  endtask

  task automatic test_undefined_ops();
    send_token(OP_NOP6, $urandom());
    send_token(OP_NOP7, $urandom());
  endtask

  // fill to the brim, push past it, then fold most of it back down
  task automatic test_stack_full();
    while (calc_depth < STACK_DEPTH) send_token(OP_PUSH, rand_operand());
    repeat (3) send_token(OP_PUSH, rand_operand());
    while (calc_depth > 3) send_token(3'($urandom_range(1, 5)), $urandom());
  endtask

  task automatic test_random_mix(input int pct, input int n_items);
    int          n;
    int          sel;
    logic [2:0]  code;
    idle_pct = pct;
    for (n = 0; n < n_items; n++) begin
      if (n == n_items / 3) test_stack_full();
      if (n == (2 * n_items) / 3) wait_results_drained();
      sel = $urandom_range(99);
      if (sel < 8) begin
        // noise: any code, any value, whatever the depth
        code = 3'($urandom_range(7));
      end else if (calc_depth < 2 || sel < ((calc_depth > 12) ? 25 : 55)) begin
        code = OP_PUSH;
      end else if (sel < 64) begin
        code = OP_DROP;
      end else begin
        code = 3'($urandom_range(OP_ADD, OP_DIV));
      end
      send_token(code, (code == OP_PUSH) ? rand_operand() : $urandom());
    end
  endtask

  // results come for one cycle only, so sample them mid-cycle
  always @(negedge clk) begin
    calc_result_t res;
    if (!rst && done) begin
      if (calc_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result top=%h depth=%0d status=%0d",
                                  top_value, depth, status));
      end else begin
        res = calc_results_q.pop_front();
        if (top_value !== res.top)
          report_mismatch($sformatf("top_value %h, want %h", top_value, res.top));
        if (depth !== res.depth)
          report_mismatch($sformatf("depth %0d, want %0d", depth, res.depth));
        if (status !== res.status)
          report_mismatch($sformatf("status %0d, want %0d", status, res.status));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 33;
    test_empty_underflow();
    test_wrap_arith();
    test_divide_cases();
    test_undefined_ops();
    test_random_mix(33, 340);
    test_random_mix(83, 340);
    test_random_mix(0, 340);
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (calc_results_q.size() != 0) report_mismatch("results still outstanding");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rsc_pkg.sv
rtl/rsc_cell.sv
rtl/rsc_divider.sv
rtl/rpn_stack_calculator.sv
tb/tb_rpn_stack_calculator.sv
